>>> sv/brst_pkg.sv
// shared types, operation codes and the popcount helper for the rank/select tree
// no dependencies; imported by brst_sel and bitmap_rank_select_tree
package brst_pkg;

   localparam int MAX_WORD_BITS = 64;
   localparam int POS_BITS      = $clog2(MAX_WORD_BITS);

   localparam logic [2:0] FN_SET    = 3'd0;
   localparam logic [2:0] FN_GET    = 3'd1;
   localparam logic [2:0] FN_REDUCE = 3'd2;
   localparam logic [2:0] FN_FIND1  = 3'd3;
   localparam logic [2:0] FN_FIND0  = 3'd4;
   localparam logic [2:0] FN_CLEAR  = 3'd5;

   typedef struct packed {
      logic                done;
      logic                found;
      logic [POS_BITS-1:0] bit_pos;
   } sel_result_type;

   function automatic logic [POS_BITS:0] popcount(input logic [MAX_WORD_BITS-1:0] word);
      logic [POS_BITS:0] sum;
      sum = '0;
      for (int i = 0; i < MAX_WORD_BITS; i++) begin
         sum = sum + (POS_BITS + 1)'(word[i]);
      end
      return sum;
   endfunction

endpackage

>>> sv/brst_mem.sv
// one write port, two read ports, registered synchronous read
// a read of the entry written at the same edge returns the new data; no dependencies
module brst_mem #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
      rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> sv/brst_sel.sv
// select unit: finds the rank-th set bit of one leaf word, one byte per cycle
// depends on brst_pkg for sel_result_type and popcount
module brst_sel #(
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WORD_BITS-1:0]     word,
   input  logic [9:0]               rank,
   output brst_pkg::sel_result_type result
);
   import brst_pkg::*;

   localparam int NCH  = (WORD_BITS + 7) / 8;
   localparam int PADW = NCH * 8;
   localparam int CNTW = $clog2(NCH + 1);

   logic                active_ff, active_in;
   logic [PADW-1:0]     word_ff, word_in;
   logic [9:0]          rank_ff, rank_in;
   logic [CNTW-1:0]     left_ff, left_in;
   logic [POS_BITS-1:0] base_ff, base_in;
   sel_result_type      res_ff, res_in;

   logic [7:0] chunk;
   logic [3:0] chunk_pop;
   logic       in_chunk;
   logic       hit;
   logic [2:0] hit_pos;
   logic [3:0] seen;

   always_comb begin
      chunk     = word_ff[7:0];
      chunk_pop = 4'(popcount(MAX_WORD_BITS'(chunk)));
      in_chunk  = rank_ff < 10'(chunk_pop);
      hit       = 1'b0;
      hit_pos   = '0;
      seen      = '0;
      for (int k = 0; k < 8; k++) begin
         if (chunk[k]) begin
            if (!hit && seen == {1'b0, rank_ff[2:0]}) begin
               hit     = 1'b1;
               hit_pos = 3'(k);
            end
            seen = seen + 4'd1;
         end
      end

      active_in = active_ff;
      word_in   = word_ff;
      rank_in   = rank_ff;
      left_in   = left_ff;
      base_in   = base_ff;
      res_in    = '0;
      if (start) begin
         active_in = 1'b1;
         word_in   = PADW'(word);
         rank_in   = rank;
         left_in   = CNTW'(NCH - 1);
         base_in   = '0;
      end else if (active_ff) begin
         if (in_chunk) begin
            active_in      = 1'b0;
            res_in.done    = 1'b1;
            res_in.found   = 1'b1;
            res_in.bit_pos = base_ff + POS_BITS'(hit_pos);
         end else if (left_ff == '0) begin
            active_in   = 1'b0;
            res_in.done = 1'b1;
         end else begin
            rank_in = rank_ff - 10'(chunk_pop);
            word_in = word_ff >> 8;
            left_in = left_ff - CNTW'(1);
            base_in = base_ff + POS_BITS'(8);
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rank_ff <= rank_in;
      left_ff <= left_in;
      base_ff <= base_in;
      if (reset) begin
         active_ff <= 1'b0;
         res_ff    <= '0;
      end else begin
         active_ff <= active_in;
         res_ff    <= res_in;
      end
   end

   assign result = res_ff;

endmodule

>>> sv/bitmap_rank_select_tree.sv
// Bitmap of LEAF_WORDS x WORD_BITS bits under a heap-ordered tree of popcounts.
// Leaf words and tree counts each sit in a brst_mem; word select runs in brst_sel.
// Depends on brst_pkg, brst_mem and brst_sel.
//
// Command channel: an operation transfers at a clock edge with start high and busy low.
// Each operation gives one result, shown for exactly one cycle with rsp_valid high;
// the receiver cannot stall, so the result is gone after that cycle.
// Steps from the start transfer to the rsp_valid cycle:
//   set / get: divide by the word size, leaf read, then write back or bit pick
//   reduce: one tree node per cycle, bottom-up, two reads each
//   find: one tree level per memory read, then the byte-serial select in the leaf
//     word; only the range check when out of range
//   clear: one entry of both memories per cycle
//   unknown operation: the result with no other step
// busy stays high until the result cycle, so operations never overlap.
// After reset a clearing pass zeroes both memories and the root count with busy
// high, with no result. rsp_total_ones is the root count of the last reduce or clear.
module bitmap_rank_select_tree #(
   parameter int WORD_BITS  = 32,
   parameter int LEAF_WORDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [9:0]  req_bit_index,
   input  logic        req_bit_value_in,
   output logic        rsp_valid,
   output logic        rsp_bit_value_out,
   output logic        rsp_found,
   output logic [9:0]  rsp_position,
   output logic [10:0] rsp_total_ones
);
   import brst_pkg::*;

   localparam int LW        = $clog2(LEAF_WORDS);
   localparam int NUM_BITS  = LEAF_WORDS * WORD_BITS;
   localparam int HALF_BITS = NUM_BITS / 2;
   localparam int CW        = $clog2(NUM_BITS + 1);
   localparam int CMPW      = (CW > 10) ? CW : 10;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int SH        = 20;
   localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PW        = 10 + $clog2(RECIP + 1);
   localparam int PFW       = LW + 8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SG_ADDR,
      ST_SG_DATA,
      ST_RED,
      ST_RED_END,
      ST_FIND_CHK,
      ST_FIND_WALK,
      ST_FIND_LEAF,
      ST_SEL
   } state_type;

   state_type      state_ff, state_in;
   logic [2:0]     func_ff, func_in;
   logic [9:0]     idx_ff, idx_in;
   logic           val_ff, val_in;
   logic [9:0]     q_ff, q_in;
   logic [BW-1:0]  bitsel_ff, bitsel_in;
   logic [LW-1:0]  ptr_ff, ptr_in;
   logic           red_go_ff, red_go_in;
   logic [LW-1:0]  red_node_ff, red_node_in;
   logic           red_leaf_ff, red_leaf_in;
   logic [LW-1:0]  node_ff, node_in;
   logic [9:0]     r_ff, r_in;
   logic [CW-1:0]  cap_ff, cap_in;
   logic           ones_ff, ones_in;
   logic [LW-1:0]  leaf_ff, leaf_in;
   logic [CW-1:0]  root_ff, root_in;
   logic           clr_rsp_ff, clr_rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_bit_ff, rsp_bit_in;
   logic           rsp_found_ff, rsp_found_in;
   logic [9:0]     rsp_pos_ff, rsp_pos_in;

   logic                 lf_we;
   logic [LW-1:0]        lf_waddr;
   logic [WORD_BITS-1:0] lf_wdata;
   logic [LW-1:0]        lf_ra_a, lf_ra_b;
   logic [WORD_BITS-1:0] lf_rd_a, lf_rd_b;
   logic                 ct_we;
   logic [LW-1:0]        ct_waddr;
   logic [CW-1:0]        ct_wdata;
   logic [LW-1:0]        ct_ra_a, ct_ra_b;
   logic [CW-1:0]        ct_rd_a, ct_rd_b;

   logic                 sel_start;
   logic [WORD_BITS-1:0] sel_word;
   sel_result_type       sel_res;

   logic [PW-1:0]        prod;
   logic [9:0]           rem;
   logic [WORD_BITS-1:0] bit_mask;
   logic [CW-1:0]        red_sum;
   logic [CMPW-1:0]      avail;
   logic [CW-1:0]        cnt;
   logic [CW-1:0]        avl;
   logic                 go_right;
   logic [LW-1:0]        child;
   logic [PFW-1:0]       pos_full;

   brst_mem #(
      .WIDTH (WORD_BITS),
      .DEPTH (LEAF_WORDS)
   ) u_leaf_mem (
      .clock     (clock),
      .wr_en     (lf_we),
      .wr_addr   (lf_waddr),
      .wr_data   (lf_wdata),
      .rd_addr_a (lf_ra_a),
      .rd_addr_b (lf_ra_b),
      .rd_data_a (lf_rd_a),
      .rd_data_b (lf_rd_b)
   );

   brst_mem #(
      .WIDTH (CW),
      .DEPTH (LEAF_WORDS)
   ) u_count_mem (
      .clock     (clock),
      .wr_en     (ct_we),
      .wr_addr   (ct_waddr),
      .wr_data   (ct_wdata),
      .rd_addr_a (ct_ra_a),
      .rd_addr_b (ct_ra_b),
      .rd_data_a (ct_rd_a),
      .rd_data_b (ct_rd_b)
   );

   brst_sel #(
      .WORD_BITS (WORD_BITS)
   ) u_sel (
      .clock  (clock),
      .reset  (reset),
      .start  (sel_start),
      .word   (sel_word),
      .rank   (r_ff),
      .result (sel_res)
   );

   always_comb begin
      prod     = PW'(idx_ff) * PW'(RECIP);
      rem      = idx_ff - 10'(q_ff * 10'(WORD_BITS));
      bit_mask = WORD_BITS'(1) << bitsel_ff;
      red_sum  = red_leaf_ff
               ? CW'(popcount(MAX_WORD_BITS'(lf_rd_a))) + CW'(popcount(MAX_WORD_BITS'(lf_rd_b)))
               : ct_rd_a + ct_rd_b;
      if (ones_ff) begin
         avail = CMPW'(root_ff);
      end else if (root_ff > CW'(NUM_BITS)) begin
         avail = '0;
      end else begin
         avail = CMPW'(CW'(NUM_BITS) - root_ff);
      end
      cnt = node_ff[LW-1] ? CW'(popcount(MAX_WORD_BITS'(lf_rd_a))) : ct_rd_a;
      if (ones_ff) begin
         avl = cnt;
      end else if (cnt > cap_ff) begin
         avl = '0;
      end else begin
         avl = cap_ff - cnt;
      end
      go_right = CMPW'(r_ff) >= CMPW'(avl);
      child    = LW'({node_ff, go_right});
      pos_full = PFW'(leaf_ff) * PFW'(WORD_BITS) + PFW'(sel_res.bit_pos);

      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      q_in         = q_ff;
      bitsel_in    = bitsel_ff;
      ptr_in       = ptr_ff;
      red_go_in    = 1'b0;
      red_node_in  = red_node_ff;
      red_leaf_in  = red_leaf_ff;
      node_in      = node_ff;
      r_in         = r_ff;
      cap_in       = cap_ff;
      ones_in      = ones_ff;
      leaf_in      = leaf_ff;
      root_in      = root_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_bit_in   = rsp_bit_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;

      lf_we     = 1'b0;
      lf_waddr  = leaf_ff;
      lf_wdata  = '0;
      lf_ra_a   = '0;
      lf_ra_b   = '0;
      ct_we     = red_go_ff;
      ct_waddr  = red_node_ff;
      ct_wdata  = red_sum;
      ct_ra_a   = '0;
      ct_ra_b   = '0;
      sel_start = 1'b0;
      sel_word  = ones_ff ? lf_rd_a : ~lf_rd_a;

      if (red_go_ff && red_node_ff == LW'(1)) begin
         root_in = red_sum;
      end

      case (state_ff)
         ST_CLEAR: begin
            lf_we    = 1'b1;
            lf_waddr = ptr_ff;
            lf_wdata = '0;
            ct_we    = 1'b1;
            ct_waddr = ptr_ff;
            ct_wdata = '0;
            root_in  = '0;
            ptr_in   = ptr_ff + LW'(1);
            if (ptr_ff == LW'(LEAF_WORDS - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = clr_rsp_ff;
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in      = req_func;
               idx_in       = req_bit_index;
               val_in       = req_bit_value_in;
               ones_in      = (req_func == FN_FIND1);
               rsp_bit_in   = 1'b0;
               rsp_found_in = 1'b0;
               rsp_pos_in   = '0;
               case (req_func)
                  FN_SET, FN_GET: begin
                     state_in = ST_DIV;
                  end
                  FN_REDUCE: begin
                     state_in = ST_RED;
                     ptr_in   = LW'(LEAF_WORDS - 1);
                  end
                  FN_FIND1, FN_FIND0: begin
                     state_in = ST_FIND_CHK;
                  end
                  FN_CLEAR: begin
                     state_in   = ST_CLEAR;
                     ptr_in     = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            q_in     = 10'(prod >> SH);
            state_in = ST_SG_ADDR;
         end
         ST_SG_ADDR: begin
            bitsel_in = BW'(rem);
            if (11'(q_ff) < 11'(LEAF_WORDS)) begin
               lf_ra_a  = LW'(q_ff);
               leaf_in  = LW'(q_ff);
               state_in = ST_SG_DATA;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_SG_DATA: begin
            if (func_ff == FN_SET) begin
               lf_we    = 1'b1;
               lf_waddr = leaf_ff;
               lf_wdata = val_ff ? (lf_rd_a | bit_mask) : (lf_rd_a & ~bit_mask);
            end else begin
               rsp_bit_in = lf_rd_a[bitsel_ff];
            end
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         ST_RED: begin
            lf_ra_a     = LW'({ptr_ff, 1'b0});
            lf_ra_b     = LW'({ptr_ff, 1'b1});
            ct_ra_a     = LW'({ptr_ff, 1'b0});
            ct_ra_b     = LW'({ptr_ff, 1'b1});
            red_go_in   = 1'b1;
            red_node_in = ptr_ff;
            red_leaf_in = ptr_ff[LW-1];
            if (ptr_ff == LW'(1)) begin
               state_in = ST_RED_END;
            end else begin
               ptr_in = ptr_ff - LW'(1);
            end
         end
         ST_RED_END: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         ST_FIND_CHK: begin
            if (CMPW'(idx_ff) < avail) begin
               node_in  = LW'(1);
               r_in     = idx_ff;
               cap_in   = CW'(HALF_BITS);
               lf_ra_a  = LW'({LW'(1), 1'b0});
               ct_ra_a  = LW'({LW'(1), 1'b0});
               state_in = ST_FIND_WALK;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_FIND_WALK: begin
            if (go_right) begin
               r_in = 10'(CMPW'(r_ff) - CMPW'(avl));
            end
            cap_in = cap_ff >> 1;
            if (node_ff[LW-1]) begin
               lf_ra_a  = child;
               leaf_in  = child;
               state_in = ST_FIND_LEAF;
            end else begin
               node_in = child;
               lf_ra_a = LW'({child, 1'b0});
               ct_ra_a = LW'({child, 1'b0});
            end
         end
         ST_FIND_LEAF: begin
            sel_start = 1'b1;
            state_in  = ST_SEL;
         end
         ST_SEL: begin
            if (sel_res.done) begin
               rsp_found_in = sel_res.found;
               rsp_pos_in   = sel_res.found ? 10'(pos_full) : '0;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      q_ff         <= q_in;
      bitsel_ff    <= bitsel_in;
      red_node_ff  <= red_node_in;
      red_leaf_ff  <= red_leaf_in;
      node_ff      <= node_in;
      r_ff         <= r_in;
      cap_ff       <= cap_in;
      ones_ff      <= ones_in;
      leaf_ff      <= leaf_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         red_go_ff    <= 1'b0;
         root_ff      <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         red_go_ff    <= red_go_in;
         root_ff      <= root_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bit_value_out = rsp_bit_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_total_ones    = 11'(root_ff);

endmodule
